// ===== rtl/core/hidkb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkb_pkg
// shared types and constants of the six-key keyboard report builder
// ----------------------------------------------------------------------------
package hidkb_pkg;

    localparam int KEY_REGS     = 5;     // usage code registers, one per key
    localparam int KEY_BITS     = 5;     // width of the key sample
    localparam int OUT_SLOTS    = 6;     // slots carried by a result item
    localparam int CODE_W       = 8;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 3;
    localparam int DEF_NUM_KEYS = 5;
    localparam int DEF_NUM_SLOTS = 6;

    localparam logic [CODE_W-1:0] EMPTY_CODE = 8'h00;

    localparam logic [CODE_W-1:0] KEY_CODE_RESET [KEY_REGS] =
        '{8'h1E, 8'h1F, 8'h20, 8'h21, 8'h39};

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_REPORT = 2'd1,
        ACT_EMPTY  = 2'd2,
        ACT_WAKEUP = 2'd3
    } action_t;

    // host side flags plus the sent mark going into the update logic
    typedef struct packed {
        logic host_ready;
        logic host_suspended;
        logic sent;
    } step_in_t;

    // decision coming back from the update logic
    typedef struct packed {
        action_t action;
        logic    sent;
    } step_out_t;

endpackage

// ===== rtl/core/hidkb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkb_in_if / hidkb_out_if
// valid/ready channels for key samples and report items
// ----------------------------------------------------------------------------
interface hidkb_in_if
    import hidkb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] keys_down;
    logic                host_ready;
    logic                host_suspended;

    modport source (output valid, keys_down, host_ready, host_suspended, input ready);
    modport sink   (input valid, keys_down, host_ready, host_suspended, output ready);
endinterface

interface hidkb_out_if
    import hidkb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [CODE_W-1:0] slot_0;
    logic [CODE_W-1:0] slot_1;
    logic [CODE_W-1:0] slot_2;
    logic [CODE_W-1:0] slot_3;
    logic [CODE_W-1:0] slot_4;
    logic [CODE_W-1:0] slot_5;

    modport source (output valid, action, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5,
                    input ready);
    modport sink   (input valid, action, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5,
                    output ready);
endinterface

// ===== rtl/core/hidkb_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkb_step
// one poll tick: key press/release slot update and report decision
// ----------------------------------------------------------------------------
module hidkb_step
    import hidkb_pkg::*;
#(
    parameter int ACT_KEYS  = DEF_NUM_KEYS,
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic [CODE_W-1:0]   codes [KEY_REGS],
    input  logic [CODE_W-1:0]   slots [NUM_SLOTS],
    input  logic [ACT_KEYS-1:0] held,
    input  logic [KEY_BITS-1:0] down,
    input  step_in_t            flags,
    output logic [CODE_W-1:0]   slots_next [NUM_SLOTS],
    output logic [ACT_KEYS-1:0] held_next,
    output step_out_t           ctl,
    output logic [CODE_W-1:0]   report_slots [OUT_SLOTS]
);

    // keys in index order, each one a lowest-slot search over the current slots
    always_comb
    begin
        logic found;
        found      = 1'b0;
        slots_next = slots;
        held_next  = held;
        for (int k = 0; k < ACT_KEYS; k++)
        begin
            if (down[k] != held_next[k])
            begin
                found = 1'b0;
                if (down[k])
                begin
                    // a zero code would look like an empty slot
                    if (codes[k] != EMPTY_CODE)
                    begin
                        for (int j = 0; j < NUM_SLOTS; j++)
                        begin
                            if (!found && slots_next[j] == EMPTY_CODE)
                            begin
                                slots_next[j] = codes[k];
                                held_next[k]  = 1'b1;
                                found         = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    for (int j = 0; j < NUM_SLOTS; j++)
                    begin
                        if (!found && slots_next[j] == codes[k])
                        begin
                            slots_next[j] = EMPTY_CODE;
                            held_next[k]  = 1'b0;
                            found         = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        ctl.action = ACT_NONE;
        ctl.sent   = flags.sent;
        if (flags.host_suspended && (|held_next))
        begin
            ctl.action = ACT_WAKEUP;
        end
        else if (flags.host_ready)
        begin
            if (|held_next)
            begin
                ctl.action = ACT_REPORT;
                ctl.sent   = 1'b1;
            end
            else if (flags.sent)
            begin
                ctl.action = ACT_EMPTY;
                ctl.sent   = 1'b0;
            end
        end
    end

    // slots are shown only in a report, slots past NUM_SLOTS read zero
    for (genvar j = 0; j < OUT_SLOTS; j++)
    begin : g_out
        if (j < NUM_SLOTS)
        begin : g_used
            assign report_slots[j] = (ctl.action == ACT_REPORT) ? slots_next[j] : EMPTY_CODE;
        end
        else
        begin : g_unused
            assign report_slots[j] = EMPTY_CODE;
        end
    end

endmodule

// ===== rtl/core/hid_six_key_report_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_six_key_report_builder
// six-slot keyboard report builder with press/release tracking and wakeup
// ----------------------------------------------------------------------------
// path: a key sample accepted into the input register moves on to the result
// register; while the result is stalled the sample waits in the input register
// throughput: one item per cycle, set by the single-pass slot update between
// the input and result registers; a stalled result holds the input stage
// reset: rst_n clears slots, held marks, the sent flag and both stages, and
// loads the usage code registers with their defaults
// ----------------------------------------------------------------------------
module hid_six_key_report_builder
    import hidkb_pkg::*;
#(
    parameter int NUM_KEYS  = DEF_NUM_KEYS,
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                clk,
    input  logic                rst_n,
    hidkb_in_if.sink            keys,
    hidkb_out_if.source         report,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // only keys with a code register can ever be pressed
    localparam int ACT_KEYS = (NUM_KEYS < KEY_REGS) ? NUM_KEYS : KEY_REGS;

    // ---------------- configuration registers ----------------
    logic [CODE_W-1:0]    code_reg [KEY_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= KEY_CODE_RESET;
        end
        else if (cfg_wr)
        begin
            for (int i = 0; i < KEY_REGS; i++)
            begin
                if (reg_idx == REG_IDX_W'(i))
                begin
                    code_reg[i] <= pwdata[CODE_W-1:0];
                end
            end
        end
    end

    // read back, addresses past the list read zero
    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < KEY_REGS; i++)
        begin
            if (reg_idx == REG_IDX_W'(i))
            begin
                prdata = {{(PDATA_W-CODE_W){1'b0}}, code_reg[i]};
            end
        end
    end

    // ---------------- input stage ----------------
    logic                s1_valid_reg;
    logic [KEY_BITS-1:0] s1_down_reg;
    logic                s1_ready_reg;
    logic                s1_susp_reg;
    logic                advance;

    // the sample moves on when the result register is free or being emptied
    assign advance    = s1_valid_reg && (!report.valid || report.ready);
    assign keys.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (keys.ready)
        begin
            s1_valid_reg <= keys.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
        begin
            s1_down_reg  <= keys.keys_down;
            s1_ready_reg <= keys.host_ready;
            s1_susp_reg  <= keys.host_suspended;
        end
    end

    // ---------------- tracking state ----------------
    logic [CODE_W-1:0]   slots_reg  [NUM_SLOTS];
    logic [CODE_W-1:0]   slots_next [NUM_SLOTS];
    logic [ACT_KEYS-1:0] held_reg;
    logic [ACT_KEYS-1:0] held_next;
    logic                sent_reg;
    step_in_t            step_in;
    step_out_t           step_out;
    logic [CODE_W-1:0]   rpt_slots [OUT_SLOTS];

    assign step_in.host_ready     = s1_ready_reg;
    assign step_in.host_suspended = s1_susp_reg;
    assign step_in.sent           = sent_reg;

    hidkb_step #(
        .ACT_KEYS  (ACT_KEYS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_step (
        .codes        (code_reg),
        .slots        (slots_reg),
        .held         (held_reg),
        .down         (s1_down_reg),
        .flags        (step_in),
        .slots_next   (slots_next),
        .held_next    (held_next),
        .ctl          (step_out),
        .report_slots (rpt_slots)
    );

    // state commits together with the result, so the next sample sees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                slots_reg[j] <= EMPTY_CODE;
            end
            held_reg <= '0;
            sent_reg <= 1'b0;
        end
        else if (advance)
        begin
            slots_reg <= slots_next;
            held_reg  <= held_next;
            sent_reg  <= step_out.sent;
        end
    end

    // ---------------- result register ----------------
    logic              out_valid_reg;
    action_t           out_action_reg;
    logic [CODE_W-1:0] out_slots_reg [OUT_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_action_reg <= step_out.action;
            out_slots_reg  <= rpt_slots;
        end
    end

    assign report.valid  = out_valid_reg;
    assign report.action = out_action_reg;
    assign report.slot_0 = out_slots_reg[0];
    assign report.slot_1 = out_slots_reg[1];
    assign report.slot_2 = out_slots_reg[2];
    assign report.slot_3 = out_slots_reg[3];
    assign report.slot_4 = out_slots_reg[4];
    assign report.slot_5 = out_slots_reg[5];

    // ---------------- checks ----------------
    logic [NUM_SLOTS-1:0] slot_busy;
    logic [OUT_SLOTS-1:0] out_busy;

    always_comb
    begin
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            slot_busy[j] = (slots_reg[j] != EMPTY_CODE);
        end
        for (int j = 0; j < OUT_SLOTS; j++)
        begin
            out_busy[j] = (out_slots_reg[j] != EMPTY_CODE);
        end
    end

    // every held key owns a filled slot
    a_held_in_slots: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(held_reg) <= $countones(slot_busy))
        else $error("held keys exceed filled slots");

    // a report item always carries at least one code
    a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_action_reg == ACT_REPORT |-> (|out_busy))
        else $error("report item with no codes");

    // items other than a report carry no codes
    a_other_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_action_reg != ACT_REPORT |-> out_busy == '0)
        else $error("non-report item carries codes");

    // a sent report arms the empty report, a wakeup leaves the flag alone
    a_sent_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_out.action == ACT_REPORT |=> sent_reg)
        else $error("sent flag not set after report");

    a_wakeup_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_out.action == ACT_WAKEUP |=> sent_reg == $past(sent_reg))
        else $error("wakeup changed sent flag");

endmodule
